>>> sv/sbc_pkg.sv
// Shared types, codes and constants of the six-axis bias calibrator.
`default_nettype none

package sbc_pkg;

    localparam int AXES       = 6;
    localparam int AXIS_W     = 16;
    localparam int ACTION_W   = 2;
    localparam int RANGE_W    = 2;
    localparam int DISCARD_W  = 10;
    localparam int COUNT_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int SAMPLE_COUNT_DEF = 256;

    localparam logic [RANGE_W-1:0]   ACCEL_RANGE_RESET   = 2'd0;
    localparam logic [DISCARD_W-1:0] DISCARD_COUNT_RESET = 10'd101;

    // One g at the 2g full scale; halves with every range step
    localparam logic [AXIS_W-1:0] ONE_G_2G = 16'd16384;

    // Axis order within the bias and sum stores
    localparam int AXIS_AZ = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START      = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ACCEL = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD_GYRO  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_COUNT = 2'd1;

    typedef logic signed [AXIS_W-1:0] axis_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        axis_t               accel_x;
        axis_t               accel_y;
        axis_t               accel_z;
        axis_t               gyro_x;
        axis_t               gyro_y;
        axis_t               gyro_z;
    } in_item_t;

    typedef struct packed {
        axis_t accel_x_out;
        axis_t accel_y_out;
        axis_t accel_z_out;
        axis_t gyro_x_out;
        axis_t gyro_y_out;
        axis_t gyro_z_out;
        logic  calibrating;
        logic  calib_done;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> sv/sbc_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface sbc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

>>> sv/sbc_mean_divider.sv
// Per-axis mean of the run sums by reciprocal multiply, three steps per run.
`default_nettype none

module sbc_mean_divider
    import sbc_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [RANGE_W-1:0]      accel_range,
    input  wire logic signed [AXIS_W + $clog2(SAMPLE_COUNT + (1 << DISCARD_W))-1:0] sums [AXES],
    output div_status_t                  status,
    output axis_t                        bias [AXES]
);

    localparam int SUM_W  = AXIS_W + $clog2(SAMPLE_COUNT + (1 << DISCARD_W));
    localparam int MAG_W  = SUM_W;
    localparam int SHIFT  = MAG_W + $clog2(SAMPLE_COUNT);
    localparam int RCP_W  = MAG_W + 2;
    localparam int PROD_W = MAG_W + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
    localparam logic [RCP_W-1:0] RECIP = RCP_FULL[RCP_W-1:0];

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ABS   = 2'd1;
    localparam logic [1:0] PH_MUL   = 2'd2;
    localparam logic [1:0] PH_APPLY = 2'd3;

    logic [1:0]         phase_reg, phase_next;
    logic [RANGE_W-1:0] range_reg;
    logic [MAG_W-1:0]   mag_reg  [AXES];
    logic               neg_reg  [AXES];
    logic [PROD_W-1:0]  prod_reg [AXES];
    logic [AXIS_W-1:0]  quot     [AXES];
    logic [AXIS_W-1:0]  one_g;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_ABS;
                end
            end
            PH_ABS:   phase_next = PH_MUL;
            PH_MUL:   phase_next = PH_APPLY;
            PH_APPLY: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Payload steps: magnitude and sign, then the reciprocal product
    always_ff @(posedge clk)
    begin
        if (start && (phase_reg == PH_IDLE))
        begin
            range_reg <= accel_range;
        end
        for (int k = 0; k < AXES; k++)
        begin
            if (phase_reg == PH_ABS)
            begin
                neg_reg[k] <= sums[k][SUM_W-1];
                mag_reg[k] <= sums[k][SUM_W-1] ? MAG_W'(-sums[k]) : MAG_W'(sums[k]);
            end
            if (phase_reg == PH_MUL)
            begin
                prod_reg[k] <= PROD_W'(mag_reg[k]) * PROD_W'(RECIP);
            end
        end
    end

    assign one_g = ONE_G_2G >> range_reg;

    // Restore the sign so the quotient truncates toward zero; keep 16 bits
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            quot[k] = prod_reg[k][SHIFT +: AXIS_W];
            bias[k] = neg_reg[k] ? axis_t'(-quot[k]) : axis_t'(quot[k]);
        end
        bias[AXIS_AZ] = neg_reg[AXIS_AZ] ? axis_t'(-quot[AXIS_AZ] - one_g)
                                         : axis_t'(quot[AXIS_AZ] - one_g);
    end

    assign status.busy = (phase_reg != PH_IDLE);
    assign status.done = (phase_reg == PH_APPLY);

endmodule

`default_nettype wire

>>> sv/sbc_calib_engine.sv
// Bias correction, run accumulation and bias store for one transaction a cycle.
`default_nettype none

module sbc_calib_engine
    import sbc_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire in_item_t             item,
    input  wire logic [RANGE_W-1:0]   accel_range,
    input  wire logic [DISCARD_W-1:0] discard_count,
    output out_item_t                 result,
    output logic                      busy
);

    // A discard count raised mid-run can let more than SAMPLE_COUNT samples in;
    // size the sums for every sample up to the largest threshold
    localparam int SUM_W = AXIS_W + $clog2(SAMPLE_COUNT + (1 << DISCARD_W));
    localparam int THR_W = COUNT_W + 1;
    localparam logic [THR_W-1:0] RUN_LEN = THR_W'(SAMPLE_COUNT);

    axis_t                    s         [AXES];
    axis_t                    diff      [AXES];
    axis_t                    bias_reg  [AXES];
    axis_t                    bias_next [AXES];
    axis_t                    div_bias  [AXES];
    logic signed [SUM_W-1:0]  sum_reg   [AXES];
    logic signed [SUM_W-1:0]  sum_next  [AXES];
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     active_reg, active_next;
    logic                     done;
    logic [THR_W-1:0]         threshold;
    div_status_t              div_status;

    assign s[0] = item.accel_x;
    assign s[1] = item.accel_y;
    assign s[2] = item.accel_z;
    assign s[3] = item.gyro_x;
    assign s[4] = item.gyro_y;
    assign s[5] = item.gyro_z;

    assign threshold = THR_W'(discard_count) + RUN_LEN;

    always_comb
    begin
        bias_next   = bias_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        active_next = active_reg;
        done        = 1'b0;
        for (int k = 0; k < AXES; k++)
        begin
            diff[k] = '0;
        end

        if (div_status.done)
        begin
            bias_next = div_bias;
        end

        if (fire)
        begin
            unique case (item.action)
                ACT_SAMPLE:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        diff[k] = s[k] - bias_reg[k];
                    end
                    if (active_reg)
                    begin
                        if (count_reg >= COUNT_W'(discard_count))
                        begin
                            for (int k = 0; k < AXES; k++)
                            begin
                                sum_next[k] = sum_reg[k] + SUM_W'(s[k]);
                            end
                        end
                        count_next = count_reg + COUNT_W'(1);
                        if ({1'b0, count_next} >= threshold)
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                    end
                end
                ACT_START:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        sum_next[k] = '0;
                    end
                    count_next  = '0;
                    active_next = 1'b1;
                end
                ACT_LOAD_ACCEL:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        bias_next[k] = s[k];
                    end
                end
                ACT_LOAD_GYRO:
                begin
                    for (int k = 3; k < AXES; k++)
                    begin
                        bias_next[k] = s[k];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                bias_reg[k] <= '0;
                sum_reg[k]  <= '0;
            end
            count_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            bias_reg   <= bias_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

    sbc_mean_divider #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (done),
        .accel_range (accel_range),
        .sums        (sum_reg),
        .status      (div_status),
        .bias        (div_bias)
    );

    assign result.accel_x_out = diff[0];
    assign result.accel_y_out = diff[1];
    assign result.accel_z_out = diff[2];
    assign result.gyro_x_out  = diff[3];
    assign result.gyro_y_out  = diff[4];
    assign result.gyro_z_out  = diff[5];
    assign result.calibrating = active_next;
    assign result.calib_done  = done;

    assign busy = div_status.busy;

endmodule

`default_nettype wire

>>> sv/six_axis_bias_calibrator_core.sv
// Top level of the six-axis bias calibrator: channels, pipeline and registers.
//
// Takes one transaction per clock unless the mean divider is busy or the result
// channel stalls, and returns one result per transaction through the input
// register, then the result register; the result register lets the next
// transaction in while a result waits. The transaction that completes a
// calibration run holds the input pipeline while the mean divider (absolute
// value, reciprocal multiply, sign and one-g removal) writes the new biases.
// No clearing pass after reset. accel_range is sampled by the completing
// transaction.
`default_nettype none

module six_axis_bias_calibrator_core
    import sbc_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    sbc_stream_if.sink                 samples,
    sbc_stream_if.source               results
);

    logic [RANGE_W-1:0]   accel_range_reg;
    logic [DISCARD_W-1:0] discard_count_reg;
    in_item_t             item_reg;
    logic                 item_valid_reg;
    out_item_t            res_reg;
    logic                 res_valid_reg;
    out_item_t            result;
    logic                 busy;
    logic                 advance;
    logic                 take;

    // Move the held transaction into the result register
    assign advance       = item_valid_reg && (!res_valid_reg || results.ready) && !busy;
    assign samples.ready = !item_valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_range_reg   <= ACCEL_RANGE_RESET;
            discard_count_reg <= DISCARD_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEL_RANGE:   accel_range_reg   <= cfg_data[RANGE_W-1:0];
                CFG_DISCARD_COUNT: discard_count_reg <= cfg_data[DISCARD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= samples.data;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    sbc_calib_engine #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (item_reg),
        .accel_range   (accel_range_reg),
        .discard_count (discard_count_reg),
        .result        (result),
        .busy          (busy)
    );

    assign results.valid = res_valid_reg;
    assign results.data  = res_reg;

endmodule

`default_nettype wire
